@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the probe reply classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IPRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IPRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define IPRC_ASSERT(lbl, clk, rst_n, prop)
`define IPRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/iprc_pkg.sv @@
// Types and constants of the ICMP probe reply classifier.
package iprc_pkg;

    // Bits needed to hold a length up to the receive buffer size.
    localparam int LEN_W              = 11;
    localparam int RECV_BUF_BYTES     = 1500;
    localparam int ICMP_HDR_BYTES     = 8;
    localparam int MIN_IP_HDR_BYTES   = 20;
    localparam int PORT_BYTES         = 4;
    localparam int PROTO_OFFSET       = 9;

    localparam logic [7:0]  PROTO_UDP           = 8'd17;
    localparam logic [7:0]  ICMP_TIME_EXCEEDED  = 8'd11;
    localparam logic [7:0]  ICMP_DEST_UNREACH   = 8'd3;
    localparam logic [7:0]  CODE_TTL_IN_TRANSIT = 8'd0;
    localparam logic [7:0]  CODE_PORT_UNREACH   = 8'd3;
    localparam logic [15:0] DST_BASE_RST        = 16'd33434;

    // Register indexes on the configuration port.
    localparam logic REG_SRC_PORT = 1'b0;
    localparam logic REG_DST_BASE = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_IGNORED = 2'd0,
        VERDICT_HOP     = 2'd1,
        VERDICT_REACHED = 2'd2,
        VERDICT_UNREACH = 2'd3
    } t_verdict;

    // Fields captured from one packet.
    typedef struct packed {
        logic [5:0]  outer_hlen;
        logic [7:0]  reply_type;
        logic [7:0]  reply_code;
        logic [5:0]  inner_hlen;
        logic [7:0]  inner_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_pkt_fields;

endpackage

@@ rtl/icmp_probe_reply_classifier_top.sv @@
// Top level of the ICMP probe reply classifier with its stream and APB ports.

// Takes a received IPv4 packet one byte per item, with tlast on its final byte, and
// gives one verdict item per packet: ignored, router hop, destination reached, or
// another unreachable with its ICMP code. A byte is accepted in every clock cycle,
// also while one verdict waits at the output; the capture stage folds one byte into
// the per-packet fields each cycle. The input stalls only when a last byte finds the
// classify stage still holding an earlier verdict behind a blocked output, and it
// moves again at the edge where the waiting verdict is taken. The last byte of a packet
// passes through the input register, capture stage and classify stage into the output
// register before its verdict is ready. Only the first 1500 bytes of a packet are
// inspected. Write the probe ports over APB only while no packet is in flight.
module icmp_probe_reply_classifier_top #(
    parameter int MAX_PACKET_BYTES = 2047
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] packet_byte, [23:8] probe_number
    input  logic        i_s_tlast,   // end_of_packet
    // Verdict stream out.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [1:0] verdict, [9:2] unreach_code, [15:10] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iprc_pkg::*;

    `include "assert_macros.svh"

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int XW = (PW > LEN_W) ? PW : LEN_W;

    // Configuration registers.
    logic [15:0] r_src_port;
    logic [15:0] r_dst_base;
    logic        cfg_wr;
    logic        cfg_idx;

    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_port <= '0;
            r_dst_base <= DST_BASE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SRC_PORT: r_src_port <= pwdata[15:0];
                REG_DST_BASE: r_dst_base <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_PORT: prdata = {16'd0, r_src_port};
            REG_DST_BASE: prdata = {16'd0, r_dst_base};
            default:      prdata = '0;
        endcase
    end

    // Pipeline control.
    logic        r_i_valid;
    logic [7:0]  r_i_byte;
    logic        r_i_last;
    logic [15:0] r_i_probe;
    logic        r_c_valid;
    logic        r_o_valid;
    logic        out_free;
    logic        c_go;
    logic        c_free;
    logic        i_go;
    logic        s_acc;

    assign out_free   = !r_o_valid || i_m_tready;
    assign c_go       = r_c_valid && out_free;
    assign c_free     = !r_c_valid || out_free;
    assign i_go       = r_i_valid && (!r_i_last || c_free);
    assign o_s_tready = !r_i_valid || i_go;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (s_acc) begin
            r_i_valid <= 1'b1;
        end else if (i_go) begin
            r_i_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_i_byte  <= i_s_tdata[7:0];
            r_i_probe <= i_s_tdata[23:8];
            r_i_last  <= i_s_tlast;
        end
    end

    // Capture stage.
    logic [PW-1:0]    r_pos;
    logic [PW-1:0]    pos_inc;
    logic [XW-1:0]    pos_ext;
    logic [XW-1:0]    inc_ext;
    logic             cap_en;
    logic             below_max;
    logic [LEN_W-1:0] pkt_len;
    t_pkt_fields      r_fields;
    t_pkt_fields      cap_fields;
    t_pkt_fields      upd_fields;

    assign pos_ext   = XW'(r_pos);
    assign below_max = pos_ext < XW'(MAX_PACKET_BYTES);
    assign cap_en    = below_max && (pos_ext < XW'(RECV_BUF_BYTES));
    assign pos_inc   = below_max ? (r_pos + PW'(1)) : r_pos;
    assign inc_ext   = XW'(pos_inc);
    assign pkt_len   = (inc_ext > XW'(RECV_BUF_BYTES)) ? LEN_W'(RECV_BUF_BYTES)
                                                       : inc_ext[LEN_W-1:0];

    iprc_capture u_capture (
        .i_pos    (pos_ext[LEN_W-1:0]),
        .i_byte   (r_i_byte),
        .i_fields (r_fields),
        .o_fields (cap_fields)
    );

    assign upd_fields = cap_en ? cap_fields : r_fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_fields <= '0;
        end else if (i_go) begin
            if (r_i_last) begin
                r_pos    <= '0;
                r_fields <= '0;
            end else begin
                r_pos    <= pos_inc;
                r_fields <= upd_fields;
            end
        end
    end

    // Classify stage holds a snapshot of the finished packet.
    t_pkt_fields      r_c_fields;
    logic [LEN_W-1:0] r_c_len;
    logic [15:0]      r_c_probe;
    t_verdict         verdict;
    logic [7:0]       code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_go && r_i_last) begin
            r_c_valid <= 1'b1;
        end else if (c_go) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && r_i_last) begin
            r_c_fields <= upd_fields;
            r_c_len    <= pkt_len;
            r_c_probe  <= r_i_probe;
        end
    end

    iprc_classify u_classify (
        .i_fields   (r_c_fields),
        .i_len      (r_c_len),
        .i_probe    (r_c_probe),
        .i_src_port (r_src_port),
        .i_dst_base (r_dst_base),
        .o_verdict  (verdict),
        .o_code     (code)
    );

    // Output register.
    t_verdict   r_o_verdict;
    logic [7:0] r_o_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_go) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_go) begin
            r_o_verdict <= verdict;
            r_o_code    <= code;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {6'd0, r_o_code, r_o_verdict};

    // A new verdict only appears after a packet sat in the classify stage.
    `IPRC_ASSERT(a_out_from_cls, i_clk, i_rst_n, $rose(r_o_valid) |-> $past(r_c_valid))
    // A finished packet leaves the position counter cleared for the next one.
    `IPRC_ASSERT(a_pos_cleared, i_clk, i_rst_n, (i_go && r_i_last) |=> (r_pos == '0))
    // A waiting snapshot is never dropped while the output is blocked.
    `IPRC_ASSERT(a_cls_held, i_clk, i_rst_n, (r_c_valid && !out_free) |=> r_c_valid)
    // The code field is zero for every verdict but another unreachable.
    `IPRC_ASSERT(a_code_zero, i_clk, i_rst_n,
        (r_o_valid && (r_o_verdict != VERDICT_UNREACH)) |-> (r_o_code == 8'd0))

endmodule

@@ rtl/iprc_capture.sv @@
// Field capture: updates the per-packet fields from one byte at its position.
module iprc_capture (
    input  logic [iprc_pkg::LEN_W-1:0] i_pos,
    input  logic [7:0]                 i_byte,
    input  iprc_pkg::t_pkt_fields      i_fields,
    output iprc_pkg::t_pkt_fields      o_fields
);
    import iprc_pkg::*;

    logic [5:0]       hl1;
    logic [5:0]       hl2;
    logic [5:0]       nib_len;
    logic [LEN_W-1:0] inner_at;
    logic [LEN_W-1:0] ports_at;

    assign nib_len = {i_byte[3:0], 2'b00};

    // Offsets use header lengths that include the current byte, so a zero
    // header length lets one byte land in several fields.
    always_comb begin
        o_fields = i_fields;
        hl1      = i_fields.outer_hlen;
        if (i_pos == '0) begin
            hl1                 = nib_len;
            o_fields.outer_hlen = nib_len;
        end
        inner_at = LEN_W'(hl1) + LEN_W'(ICMP_HDR_BYTES);
        hl2      = i_fields.inner_hlen;
        if (i_pos == inner_at) begin
            hl2                 = nib_len;
            o_fields.inner_hlen = nib_len;
        end
        ports_at = inner_at + LEN_W'(hl2);

        if (i_pos == LEN_W'(hl1))
            o_fields.reply_type = i_byte;
        if (i_pos == LEN_W'(hl1) + LEN_W'(1))
            o_fields.reply_code = i_byte;
        if (i_pos == inner_at + LEN_W'(PROTO_OFFSET))
            o_fields.inner_proto = i_byte;
        if (i_pos == ports_at)
            o_fields.src_port[15:8] = i_byte;
        if (i_pos == ports_at + LEN_W'(1))
            o_fields.src_port[7:0] = i_byte;
        if (i_pos == ports_at + LEN_W'(2))
            o_fields.dst_port[15:8] = i_byte;
        if (i_pos == ports_at + LEN_W'(3))
            o_fields.dst_port[7:0] = i_byte;
    end

endmodule

@@ rtl/iprc_classify.sv @@
// Verdict logic: length checks, port match and ICMP type decode.
module iprc_classify (
    input  iprc_pkg::t_pkt_fields      i_fields,
    input  logic [iprc_pkg::LEN_W-1:0] i_len,
    input  logic [15:0]                i_probe,
    input  logic [15:0]                i_src_port,
    input  logic [15:0]                i_dst_base,
    output iprc_pkg::t_verdict         o_verdict,
    output logic [7:0]                 o_code
);
    import iprc_pkg::*;

    logic [LEN_W-1:0] icmp_len;
    logic [15:0]      exp_dst;
    logic             too_short;
    logic             hop;
    logic             unreach;
    logic             short_inner;
    logic             short_ports;
    logic             match;

    assign exp_dst     = i_dst_base + i_probe;
    assign too_short   = i_len < (LEN_W'(i_fields.outer_hlen) + LEN_W'(ICMP_HDR_BYTES));
    assign icmp_len    = i_len - LEN_W'(i_fields.outer_hlen);
    assign hop         = (i_fields.reply_type == ICMP_TIME_EXCEEDED) &&
                         (i_fields.reply_code == CODE_TTL_IN_TRANSIT);
    assign unreach     = (i_fields.reply_type == ICMP_DEST_UNREACH);
    assign short_inner = icmp_len < LEN_W'(ICMP_HDR_BYTES + MIN_IP_HDR_BYTES);
    assign short_ports = icmp_len < (LEN_W'(ICMP_HDR_BYTES + PORT_BYTES) +
                                     LEN_W'(i_fields.inner_hlen));
    assign match       = (i_fields.inner_proto == PROTO_UDP) &&
                         (i_fields.src_port == i_src_port) &&
                         (i_fields.dst_port == exp_dst);

    always_comb begin
        o_verdict = VERDICT_IGNORED;
        if (!too_short && (hop || unreach) && !short_inner && !short_ports && match) begin
            if (hop)
                o_verdict = VERDICT_HOP;
            else if (i_fields.reply_code == CODE_PORT_UNREACH)
                o_verdict = VERDICT_REACHED;
            else
                o_verdict = VERDICT_UNREACH;
        end
        o_code = (o_verdict == VERDICT_UNREACH) ? i_fields.reply_code : 8'd0;
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the ICMP probe reply classifier top level.
`timescale 1ns / 1ps

module tb;
    import iprc_pkg::*;

    localparam int MAX_PKT_BYTES   = 2047;
    localparam int CLK_PERIOD      = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int NUM_PHASES      = 5;

    // Tracks per-packet capture state and the verdict items still owed by the block.
    class verdict_scoreboard;
        logic [15:0] src_port;
        logic [15:0] dst_base;
        int          pos;
        int          hl1;
        int          hl2;
        logic [7:0]  rtype;
        logic [7:0]  rcode;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] verdict_q[$];
        int          errors;
        int          bytes_seen;
        int          packets;
        int          verdict_count[4];

        function new();
            src_port   = 16'd0;
            dst_base   = DST_BASE_RST;
            errors     = 0;
            bytes_seen = 0;
            packets    = 0;
            foreach (verdict_count[k]) verdict_count[k] = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            pos   = 0;
            hl1   = 0;
            hl2   = 0;
            rtype = 8'd0;
            rcode = 8'd0;
            proto = 8'd0;
            sport = 16'd0;
            dport = 16'd0;
        endfunction

        function void note_byte(logic [7:0] b, logic last, logic [15:0] probe);
            int          inner_at;
            int          ports_at;
            int          n;
            int          icmplen;
            logic [15:0] want_dst;
            logic        hop;
            logic        unr;
            t_verdict    v;
            bytes_seen++;
            // Offsets follow the header lengths known at this byte, so fields may overlap.
            if (pos < MAX_PKT_BYTES && pos < RECV_BUF_BYTES) begin
                if (pos == 0) hl1 = int'(b[3:0]) * 4;
                inner_at = hl1 + ICMP_HDR_BYTES;
                if (pos == inner_at) hl2 = int'(b[3:0]) * 4;
                ports_at = inner_at + hl2;
                if (pos == hl1) rtype = b;
                if (pos == hl1 + 1) rcode = b;
                if (pos == inner_at + PROTO_OFFSET) proto = b;
                if (pos == ports_at) sport[15:8] = b;
                if (pos == ports_at + 1) sport[7:0] = b;
                if (pos == ports_at + 2) dport[15:8] = b;
                if (pos == ports_at + 3) dport[7:0] = b;
            end
            if (pos < MAX_PKT_BYTES) pos++;
            if (last) begin
                n        = (pos > RECV_BUF_BYTES) ? RECV_BUF_BYTES : pos;
                icmplen  = n - hl1;
                hop      = (rtype == ICMP_TIME_EXCEEDED) && (rcode == CODE_TTL_IN_TRANSIT);
                unr      = (rtype == ICMP_DEST_UNREACH);
                want_dst = dst_base + probe;
                v        = VERDICT_IGNORED;
                if (icmplen >= ICMP_HDR_BYTES && (hop || unr) &&
                    icmplen >= ICMP_HDR_BYTES + MIN_IP_HDR_BYTES &&
                    icmplen >= ICMP_HDR_BYTES + hl2 + PORT_BYTES &&
                    proto == PROTO_UDP && sport == src_port && dport == want_dst) begin
                    if (hop) begin
                        v = VERDICT_HOP;
                    end else if (rcode == CODE_PORT_UNREACH) begin
                        v = VERDICT_REACHED;
                    end else begin
                        v = VERDICT_UNREACH;
                    end
                end
                verdict_q.push_back({6'd0, (v == VERDICT_UNREACH) ? rcode : 8'd0, v});
                verdict_count[int'(v)]++;
                packets++;
                clear_packet();
            end
        endfunction

        function void check_verdict(logic [15:0] got);
            logic [15:0] want;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected verdict item %h", got);
                return;
            end
            want = verdict_q.pop_front();
            if (got[1:0] !== want[1:0] || got[9:2] !== want[9:2] || got[15:10] !== want[15:10])
            begin
                errors++;
                if (errors <= 10)
                    $display("verdict/code/pad mismatch: expected %0d/%0d/%h, got %0d/%0d/%h",
                             want[1:0], want[9:2], want[15:10], got[1:0], got[9:2], got[15:10]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    verdict_scoreboard sb = new();

    logic [7:0]  pkt_bytes[$];
    logic [15:0] cfg_src;
    logic [15:0] cfg_base;
    bit          sender_idles;
    bit          hold_off_req;
    int          burst_left;
    int          idle_cycles;
    int          settings_used;

    icmp_probe_reply_classifier_top #(
        .MAX_PACKET_BYTES(MAX_PKT_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_verdict(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("icmp_probe_reply_classifier_top verification failed");
            $finish;
        end
    end

    // Receiver: random stretches of steady, loose and tight ready, plus one long hold-off.
    initial begin : ready_pattern
        int mode;
        int mode_left;
        bit held;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        i_m_tready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] probe);
        int gap;
        gap = 0;
        if (sender_idles) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {probe, b};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(b, last, probe);
    endtask

    task automatic send_packet(input logic [15:0] probe);
        foreach (pkt_bytes[k]) send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1, probe);
    endtask

    // Random bytes with the reply fields laid over them where the packet is long enough.
    task automatic make_reply(input int ohl, input int ihl, input logic [7:0] rtype,
                              input logic [7:0] rcode, input logic [7:0] proto,
                              input logic [15:0] sport, input logic [15:0] dport,
                              input int len);
        int h1;
        int ports;
        h1    = ohl * 4;
        ports = h1 + ICMP_HDR_BYTES + ihl * 4;
        pkt_bytes.delete();
        repeat (len) pkt_bytes.push_back(8'($urandom));
        pkt_bytes[0] = {pkt_bytes[0][7:4], 4'(ohl)};
        if (h1 < len) pkt_bytes[h1] = rtype;
        if (h1 + 1 < len) pkt_bytes[h1 + 1] = rcode;
        if (h1 + 8 < len) pkt_bytes[h1 + 8] = {pkt_bytes[h1 + 8][7:4], 4'(ihl)};
        if (h1 + 8 + PROTO_OFFSET < len) pkt_bytes[h1 + 8 + PROTO_OFFSET] = proto;
        if (ports < len) pkt_bytes[ports] = sport[15:8];
        if (ports + 1 < len) pkt_bytes[ports + 1] = sport[7:0];
        if (ports + 2 < len) pkt_bytes[ports + 2] = dport[15:8];
        if (ports + 3 < len) pkt_bytes[ports + 3] = dport[7:0];
    endtask

    task automatic random_packet();
        int          ohl;
        int          ihl;
        int          len;
        int          full;
        int          pick;
        logic [7:0]  rtype;
        logic [7:0]  rcode;
        logic [7:0]  proto;
        logic [15:0] probe;
        logic [15:0] sport;
        logic [15:0] dport;
        probe = 16'($urandom);
        ohl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        pick  = $urandom_range(0, 9);
        if (pick < 4) begin
            rtype = ICMP_TIME_EXCEEDED;
            rcode = ($urandom_range(0, 5) == 0) ? 8'($urandom) : CODE_TTL_IN_TRANSIT;
        end else if (pick < 8) begin
            rtype = ICMP_DEST_UNREACH;
            rcode = ($urandom_range(0, 1) == 0) ? CODE_PORT_UNREACH : 8'($urandom);
        end else begin
            rtype = 8'($urandom);
            rcode = 8'($urandom);
        end
        proto = ($urandom_range(0, 7) == 0) ? 8'($urandom) : PROTO_UDP;
        sport = ($urandom_range(0, 7) == 0) ? 16'($urandom) : cfg_src;
        dport = cfg_base + probe;
        if ($urandom_range(0, 7) == 0) dport = dport + 16'($urandom_range(1, 3));
        full = ohl * 4 + ((ihl * 4 + 12 > 28) ? ihl * 4 + 12 : 28);
        if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, full);
        end else begin
            len = full + $urandom_range(0, 20);
        end
        // Some packets are plain noise.
        if ($urandom_range(0, 9) == 0) begin
            make_reply($urandom_range(0, 15), $urandom_range(0, 15), 8'($urandom), 8'($urandom),
                       8'($urandom), 16'($urandom), 16'($urandom), $urandom_range(1, 64));
        end else begin
            make_reply(ohl, ihl, rtype, rcode, proto, sport, dport, len);
        end
        send_packet(probe);
    endtask

    // Writes one probe port register and reads it back.
    task automatic set_probe_reg(input logic idx, input logic [15:0] val);
        logic [2:0] addr;
        addr = {idx, 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {16'h0000, val}) begin
            sb.errors++;
            if (sb.errors <= 10)
                $display("register %0d read back %h, expected %h", idx, prdata, val);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SRC_PORT) begin
            cfg_src     = val;
            sb.src_port = val;
        end else begin
            cfg_base    = val;
            sb.dst_base = val;
        end
    endtask

    // The block may still hold a packet in its pipeline when the queue runs dry.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          phase;
        int          start_pkts;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 24'd0;
        i_s_tlast  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 3'd0;
        pwdata     <= 32'd0;
        cfg_src       = 16'd0;
        cfg_base      = DST_BASE_RST;
        sender_idles  = 1'b1;
        hold_off_req  = 1'b0;
        burst_left    = 0;
        settings_used = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed packets under the reset port settings.
        make_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_IN_TRANSIT, PROTO_UDP, cfg_src,
                   cfg_base, 48);
        send_packet(16'h0000);
        make_reply(5, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, PROTO_UDP, cfg_src,
                   cfg_base + 16'hFFFF, 49);
        send_packet(16'hFFFF);
        make_reply(5, 5, ICMP_DEST_UNREACH, 8'hFF, PROTO_UDP, cfg_src, cfg_base + 16'h1234, 60);
        send_packet(16'h1234);
        make_reply(5, 5, ICMP_DEST_UNREACH, 8'h00, PROTO_UDP, cfg_src, cfg_base + 16'h00FF, 48);
        send_packet(16'h00FF);
        // One byte short of the quoted inner header.
        make_reply(5, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, PROTO_UDP, cfg_src, cfg_base, 47);
        send_packet(16'h0000);
        // A single byte is too short for any ICMP header.
        make_reply(15, 5, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1);
        send_packet(16'hFFFF);
        // Outer IHL of zero puts the ICMP type on byte 0, which then sets the length.
        make_reply(0, 5, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, PROTO_UDP, cfg_src, cfg_base, 40);
        send_packet(16'h0000);
        make_reply(5, 15, ICMP_TIME_EXCEEDED, CODE_TTL_IN_TRANSIT, PROTO_UDP, cfg_src,
                   cfg_base + 16'h8000, 92);
        send_packet(16'h8000);
        // Inner IHL of zero makes the port bytes overlap the quoted header.
        make_reply(15, 0, ICMP_DEST_UNREACH, CODE_PORT_UNREACH, PROTO_UDP, cfg_src,
                   cfg_base + 16'h0001, 88);
        send_packet(16'h0001);
        make_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_IN_TRANSIT, 8'd6, cfg_src, cfg_base, 48);
        send_packet(16'h0000);
        make_reply(5, 5, ICMP_TIME_EXCEEDED, CODE_TTL_IN_TRANSIT, PROTO_UDP, cfg_src ^ 16'h0001,
                   cfg_base, 48);
        send_packet(16'h0000);
        make_reply(5, 5, ICMP_TIME_EXCEEDED, 8'h01, PROTO_UDP, cfg_src, cfg_base, 48);
        send_packet(16'h0000);
        wait_idle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    set_probe_reg(REG_SRC_PORT, 16'hFFFF);
                    set_probe_reg(REG_DST_BASE, 16'h0000);
                end
                1: begin
                    set_probe_reg(REG_SRC_PORT, 16'h0000);
                    set_probe_reg(REG_DST_BASE, 16'hFFFF);
                end
                4: begin
                    set_probe_reg(REG_SRC_PORT, 16'hFFFF);
                    set_probe_reg(REG_DST_BASE, 16'hFFFF);
                end
                default: begin
                    set_probe_reg(REG_SRC_PORT, 16'($urandom));
                    set_probe_reg(REG_DST_BASE, 16'($urandom));
                end
            endcase
            settings_used++;
            sender_idles = (phase != 1);
            start_pkts   = sb.packets;

            if (phase == 3) begin
                // Many tiny packets back to back while the receiver holds off,
                // so verdicts back up and the input stalls.
                sender_idles = 1'b0;
                hold_off_req = 1'b1;
                repeat (16) begin
                    make_reply($urandom_range(0, 15), 5, 8'($urandom), 8'($urandom), PROTO_UDP,
                               cfg_src, cfg_base, $urandom_range(1, 4));
                    send_packet(16'($urandom));
                end
                sender_idles = 1'b1;
            end

            while (sb.packets - start_pkts < 1)
                random_packet();
            wait_idle();
        end

        $display("Covered %0d packets, %0d bytes, %0d port settings and one long hold-off.",
                 sb.packets, sb.bytes_seen, settings_used);
        $display("Verdicts: %0d ignored, %0d hop, %0d reached, %0d other; %0d errors.",
                 sb.verdict_count[0], sb.verdict_count[1], sb.verdict_count[2],
                 sb.verdict_count[3], sb.errors);
        if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
            $display("icmp_probe_reply_classifier_top verification clean");
        end else begin
            $display("icmp_probe_reply_classifier_top verification failed");
        end
        $finish;
    end

endmodule
